/* sv/fxa_pkg.sv */
// Shared types and constants of the fixed-point arithmetic unit.
// Has no dependencies; used by the top level and the bench.
package fxa_pkg;

    // Width of the operand and result ports.
    localparam int WORD_W = 32;

    // Configuration register port geometry.
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_INT_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_MODE = 2'd2;

    // Configuration field widths and reset values.
    localparam int INT_BITS_W  = 6;
    localparam int FRAC_BITS_W = 5;
    localparam logic [INT_BITS_W-1:0]  INT_BITS_RST  = 6'd16;
    localparam logic [FRAC_BITS_W-1:0] FRAC_BITS_RST = 5'd16;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // Rounding modes.
    typedef enum logic [1:0] {
        RND_ZERO = 2'd0,
        RND_EVEN = 2'd1,
        RND_POS  = 2'd2,
        RND_NEG  = 2'd3
    } round_t;

endpackage

/* sv/fixed_point_alu_rounding.sv */
// Top level of the Q(A.B) fixed-point unit: add, subtract, multiply, divide.
// Uses fxa_pkg and the divider pipeline fxa_div_pipe.
//
//  channel   | handshake            | words
//  ----------+----------------------+----------------------------------------
//  command   | start, busy          | operation, operand_x, operand_y
//  result    | done                 | result_word, div_by_zero
//  config    | cfg_write            | cfg_index, cfg_data
//
// Every word passes stages 1 to 3, the bit-per-stage divider, the rounding stage and
// the output register from start to done. One word may enter every cycle
// and busy stays low. Reset clears all valid bits and loads the register
// defaults (A=16, B=16, round toward zero). done lasts one cycle per word;
// the receiver cannot stall and the pipeline never holds.
module fixed_point_alu_rounding #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        operation,
    input  logic [fxa_pkg::WORD_W-1:0]        operand_x,
    input  logic [fxa_pkg::WORD_W-1:0]        operand_y,
    output logic                              done,
    output logic [fxa_pkg::WORD_W-1:0]        result_word,
    output logic                              div_by_zero,
    input  logic                              cfg_write,
    input  logic [fxa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fxa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int LIM    = (MAX_WIDTH < fxa_pkg::WORD_W) ? MAX_WIDTH : fxa_pkg::WORD_W;
    localparam int LW     = $clog2(LIM + 1);
    localparam int NUMW   = 2 * LIM - 1;
    localparam int PW     = 2 * LIM;
    localparam int SIDE_W = 2 + 1 + LIM + 1 + LIM + 3;
    localparam int LAT    = NUMW + 5;

    // Configuration registers.
    logic [fxa_pkg::INT_BITS_W-1:0]  int_bits_reg;
    logic [fxa_pkg::FRAC_BITS_W-1:0] frac_bits_reg;
    fxa_pkg::round_t                 round_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_bits_reg   <= fxa_pkg::INT_BITS_RST;
            frac_bits_reg  <= fxa_pkg::FRAC_BITS_RST;
            round_mode_reg <= fxa_pkg::RND_ZERO;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fxa_pkg::REG_INT_BITS:   int_bits_reg   <= cfg_data[fxa_pkg::INT_BITS_W-1:0];
                fxa_pkg::REG_FRAC_BITS:  frac_bits_reg  <= cfg_data[fxa_pkg::FRAC_BITS_W-1:0];
                fxa_pkg::REG_ROUND_MODE: round_mode_reg <= fxa_pkg::round_t'(cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // Effective widths after clamping, and the word mask.
    logic [LW-1:0]  a_eff;
    logic [LW-1:0]  b_eff;
    logic [LW-1:0]  w_eff;
    logic [LW-1:0]  room;
    logic [LIM-1:0] mask;
    logic [LIM-1:0] sign_bit;

    always_comb
    begin
        if (int_bits_reg == '0)
            a_eff = LW'(1);
        else if ({1'b0, int_bits_reg} > 7'(LIM))
            a_eff = LW'(LIM);
        else
            a_eff = LW'(int_bits_reg);
        room = LW'(LIM) - a_eff;
        if (7'(frac_bits_reg) > 7'(room))
            b_eff = room;
        else
            b_eff = LW'(frac_bits_reg);
        w_eff    = a_eff + b_eff;
        mask     = ~({LIM{1'b1}} << w_eff);
        sign_bit = LIM'(1) << (w_eff - LW'(1));
    end

    // Stage 0 logic: mask operands, take signs and magnitudes.
    logic           accept;
    logic [LIM-1:0] x_in;
    logic [LIM-1:0] y_in;
    logic           sx;
    logic           sy;
    logic [LIM-1:0] mx_in;
    logic [LIM-1:0] my_in;
    logic [LIM-1:0] sum_in;
    fxa_pkg::op_t   op_in;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        op_in  = fxa_pkg::op_t'(operation);
        x_in   = operand_x[LIM-1:0] & mask;
        y_in   = operand_y[LIM-1:0] & mask;
        sx     = |(x_in & sign_bit);
        sy     = |(y_in & sign_bit);
        mx_in  = sx ? ((~x_in + LIM'(1)) & mask) : x_in;
        my_in  = sy ? ((~y_in + LIM'(1)) & mask) : y_in;
        sum_in = (op_in == fxa_pkg::OP_SUB) ? ((x_in - y_in) & mask)
                                            : ((x_in + y_in) & mask);
    end

    // Stage 1 registers.
    logic           s1_vld_reg;
    fxa_pkg::op_t   s1_op_reg;
    logic           s1_neg_reg;
    logic [LIM-1:0] s1_mx_reg;
    logic [LIM-1:0] s1_my_reg;
    logic [LIM-1:0] s1_sum_reg;
    logic           s1_dz_reg;

    // Stage 2 registers.
    logic           s2_vld_reg;
    fxa_pkg::op_t   s2_op_reg;
    logic           s2_neg_reg;
    logic [LIM-1:0] s2_my_reg;
    logic [LIM-1:0] s2_sum_reg;
    logic           s2_dz_reg;
    logic [PW-1:0]  s2_prod_reg;
    logic [NUMW-1:0] s2_num_reg;

    // Stage 3 registers.
    logic           s3_vld_reg;
    fxa_pkg::op_t   s3_op_reg;
    logic           s3_neg_reg;
    logic [LIM-1:0] s3_my_reg;
    logic [LIM-1:0] s3_sum_reg;
    logic           s3_dz_reg;
    logic [NUMW-1:0] s3_num_reg;
    logic [LIM-1:0] s3_mq_reg;
    logic           s3_mgt_reg;
    logic           s3_meq_reg;
    logic           s3_mnz_reg;

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // Stage 1: capture magnitudes, sign of the result and the wrapped sum.
    always_ff @(posedge clk)
    begin
        s1_op_reg  <= op_in;
        s1_neg_reg <= sx ^ sy;
        s1_mx_reg  <= mx_in;
        s1_my_reg  <= my_in;
        s1_sum_reg <= sum_in;
        s1_dz_reg  <= (op_in == fxa_pkg::OP_DIV) && (y_in == '0);
    end

    // Stage 2: multiply magnitudes and align the dividend.
    always_ff @(posedge clk)
    begin
        s2_op_reg   <= s1_op_reg;
        s2_neg_reg  <= s1_neg_reg;
        s2_my_reg   <= s1_my_reg;
        s2_sum_reg  <= s1_sum_reg;
        s2_dz_reg   <= s1_dz_reg;
        s2_prod_reg <= PW'(s1_mx_reg) * PW'(s1_my_reg);
        s2_num_reg  <= NUMW'(s1_mx_reg) << b_eff;
    end

    // Stage 3 logic: scale the product and grade the dropped fraction.
    logic [PW-1:0] prod_frac;
    logic [PW:0]   prod_twice;
    logic [PW:0]   prod_unit;

    always_comb
    begin
        prod_frac  = s2_prod_reg & ~({PW{1'b1}} << b_eff);
        prod_twice = {prod_frac, 1'b0};
        prod_unit  = (PW+1)'(1) << b_eff;
    end

    always_ff @(posedge clk)
    begin
        s3_op_reg  <= s2_op_reg;
        s3_neg_reg <= s2_neg_reg;
        s3_my_reg  <= s2_my_reg;
        s3_sum_reg <= s2_sum_reg;
        s3_dz_reg  <= s2_dz_reg;
        s3_num_reg <= s2_num_reg;
        s3_mq_reg  <= LIM'(s2_prod_reg >> b_eff);
        s3_mgt_reg <= prod_twice > prod_unit;
        s3_meq_reg <= prod_twice == prod_unit;
        s3_mnz_reg <= |prod_frac;
    end

    // Divider pipeline; everything else rides along as sideband.
    logic [SIDE_W-1:0] side_in;
    logic [SIDE_W-1:0] side_out;
    logic              dv_vld;
    logic [LIM-1:0]    dv_quo;
    logic [LIM-1:0]    dv_rem;
    logic [LIM-1:0]    dv_den;

    assign side_in = {s3_op_reg, s3_neg_reg, s3_sum_reg, s3_dz_reg, s3_mq_reg,
                      s3_mgt_reg, s3_meq_reg, s3_mnz_reg};

    fxa_div_pipe #(
        .NUM_W  (NUMW),
        .DIV_W  (LIM),
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s3_vld_reg),
        .numerator   (s3_num_reg),
        .divisor     (s3_my_reg),
        .in_side     (side_in),
        .out_valid   (dv_vld),
        .quotient    (dv_quo),
        .remainder   (dv_rem),
        .out_divisor (dv_den),
        .out_side    (side_out)
    );

    logic [1:0]     d_op_bits;
    fxa_pkg::op_t   d_op;
    logic           d_neg;
    logic [LIM-1:0] d_sum;
    logic           d_dz;
    logic [LIM-1:0] d_mq;
    logic           d_mgt;
    logic           d_meq;
    logic           d_mnz;

    always_comb
    begin
        {d_op_bits, d_neg, d_sum, d_dz, d_mq, d_mgt, d_meq, d_mnz} = side_out;
        d_op = fxa_pkg::op_t'(d_op_bits);
    end

    // Rounding stage: pick the truncated value and its grade, then round.
    logic [LIM-1:0] q_sel;
    logic           gt_sel;
    logic           eq_sel;
    logic           nz_sel;
    logic           inc;
    logic [LIM:0]   rem_twice;

    always_comb
    begin
        rem_twice = {dv_rem, 1'b0};
        if (d_op == fxa_pkg::OP_MUL)
        begin
            q_sel  = d_mq;
            gt_sel = d_mgt;
            eq_sel = d_meq;
            nz_sel = d_mnz;
        end
        else
        begin
            q_sel  = dv_quo;
            gt_sel = rem_twice > {1'b0, dv_den};
            eq_sel = rem_twice == {1'b0, dv_den};
            nz_sel = |dv_rem;
        end
        case (round_mode_reg)
            fxa_pkg::RND_ZERO: inc = 1'b0;
            fxa_pkg::RND_EVEN: inc = gt_sel || (eq_sel && q_sel[0]);
            fxa_pkg::RND_POS:  inc = nz_sel && !d_neg;
            fxa_pkg::RND_NEG:  inc = nz_sel && d_neg;
            default:           inc = 1'b0;
        endcase
    end

    logic           r_vld_reg;
    fxa_pkg::op_t   r_op_reg;
    logic           r_neg_reg;
    logic [LIM-1:0] r_sum_reg;
    logic           r_dz_reg;
    logic [LIM-1:0] r_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_vld_reg <= 1'b0;
        end
        else
        begin
            r_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        r_op_reg  <= d_op;
        r_neg_reg <= d_neg;
        r_sum_reg <= d_sum;
        r_dz_reg  <= d_dz;
        r_q_reg   <= q_sel + LIM'(inc);
    end

    // Output stage: apply the sign, wrap to the word width, pick the result.
    logic [LIM-1:0] res_next;
    logic           dz_next;

    always_comb
    begin
        dz_next = 1'b0;
        case (r_op_reg)
            fxa_pkg::OP_ADD,
            fxa_pkg::OP_SUB: res_next = r_sum_reg;
            fxa_pkg::OP_MUL: res_next = (r_neg_reg ? (~r_q_reg + LIM'(1)) : r_q_reg) & mask;
            fxa_pkg::OP_DIV:
            begin
                dz_next  = r_dz_reg;
                res_next = r_dz_reg ? '0
                         : ((r_neg_reg ? (~r_q_reg + LIM'(1)) : r_q_reg) & mask);
            end
            default:         res_next = '0;
        endcase
    end

    logic           done_reg;
    logic [LIM-1:0] result_reg;
    logic           dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= r_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_next;
        dz_reg     <= dz_next;
    end

    assign done        = done_reg;
    assign result_word = fxa_pkg::WORD_W'(result_reg);
    assign div_by_zero = dz_reg;

`ifndef NO_ASSERTIONS
    // A result appears exactly the pipeline latency after its command.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a command at the pipeline latency");

    // A zero divisor always yields a zero word.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_by_zero) |-> (result_word == '0))
        else $error("divide by zero with a nonzero result");

    // Bits above the configured word width stay clear.
    a_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result_word[LIM-1:0] & ~mask) == '0))
        else $error("result has bits above the word width");
`endif

endmodule

/* sv/fxa_div_pipe.sv */
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on nothing but its parameters; instantiated by the top level.
module fxa_div_pipe #(
    parameter int NUM_W  = 63,
    parameter int DIV_W  = 32,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  numerator,
    input  logic [DIV_W-1:0]  divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [DIV_W-1:0]  quotient,
    output logic [DIV_W-1:0]  remainder,
    output logic [DIV_W-1:0]  out_divisor,
    output logic [SIDE_W-1:0] out_side
);

    // Stage links; index 0 is the input, index k+1 the output of stage k.
    logic              vld_w  [0:NUM_W];
    logic [NUM_W-1:0]  num_w  [0:NUM_W];
    logic [DIV_W-1:0]  den_w  [0:NUM_W];
    logic [DIV_W-1:0]  rem_w  [0:NUM_W];
    logic [DIV_W-1:0]  quo_w  [0:NUM_W];
    logic [SIDE_W-1:0] side_w [0:NUM_W];

    assign vld_w[0]  = in_valid;
    assign num_w[0]  = numerator;
    assign den_w[0]  = divisor;
    assign rem_w[0]  = '0;
    assign quo_w[0]  = '0;
    assign side_w[0] = in_side;

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              vld_reg;
        logic [NUM_W-1:0]  num_reg;
        logic [DIV_W-1:0]  den_reg;
        logic [DIV_W-1:0]  rem_reg;
        logic [DIV_W-1:0]  quo_reg;
        logic [SIDE_W-1:0] side_reg;
        logic [DIV_W:0]    trial;
        logic              fits;
        logic [DIV_W-1:0]  rem_next;

        // Bring down the next numerator bit and try a subtract.
        always_comb
        begin
            trial    = {rem_w[k], num_w[k][NUM_W-1]};
            fits     = (trial >= {1'b0, den_w[k]});
            rem_next = fits ? DIV_W'(trial - {1'b0, den_w[k]}) : DIV_W'(trial);
        end

        // Valid bit of the stage.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else
            begin
                vld_reg <= vld_w[k];
            end
        end

        // Stage data.
        always_ff @(posedge clk)
        begin
            num_reg  <= num_w[k] << 1;
            den_reg  <= den_w[k];
            rem_reg  <= rem_next;
            quo_reg  <= {quo_w[k][DIV_W-2:0], fits};
            side_reg <= side_w[k];
        end

        assign vld_w[k+1]  = vld_reg;
        assign num_w[k+1]  = num_reg;
        assign den_w[k+1]  = den_reg;
        assign rem_w[k+1]  = rem_reg;
        assign quo_w[k+1]  = quo_reg;
        assign side_w[k+1] = side_reg;
    end

    assign out_valid   = vld_w[NUM_W];
    assign quotient    = quo_w[NUM_W];
    assign remainder   = rem_w[NUM_W];
    assign out_divisor = den_w[NUM_W];
    assign out_side    = side_w[NUM_W];

endmodule

/* bench/fixed_point_alu_rounding_tb.sv */
// Self-checking bench for the Q(A.B) fixed-point unit: directed table, then random words.
// Depends on fxa_pkg and the fixed_point_alu_rounding top level.
module fixed_point_alu_rounding_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAT       = 2 * 32 + 4;
    localparam int N_RANDOM  = 1950;
    localparam int CYC_LIMIT = 400000;

    typedef struct packed {
        logic         has_exp;
        fxa_pkg::op_t op;
        logic [31:0]  x;
        logic [31:0]  y;
        logic [31:0]  res;
        logic         dz;
    } row_t;

    typedef struct packed {
        logic [31:0] res;
        logic        dz;
    } alu_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] operation = 2'd0;
    logic [31:0] operand_x = 32'd0;
    logic [31:0] operand_y = 32'd0;
    logic done;
    logic [31:0] result_word;
    logic div_by_zero;
    logic cfg_write = 1'b0;
    logic [fxa_pkg::CFG_IDX_W-1:0] cfg_index = fxa_pkg::REG_INT_BITS;
    logic [fxa_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the configuration registers.
    logic [5:0] sh_int = 6'd16;
    logic [4:0] sh_frac = 5'd16;
    fxa_pkg::round_t sh_rnd = fxa_pkg::RND_ZERO;

    alu_out_t pending_q[$];
    int fails = 0;
    int cycles = 0;

    fixed_point_alu_rounding u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .operand_x(operand_x), .operand_y(operand_y),
        .done(done), .result_word(result_word), .div_by_zero(div_by_zero),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Round a magnitude quotient q with remainder r over divisor d.
    function automatic logic [63:0] round_q(logic [63:0] q, logic [63:0] r,
                                            logic [63:0] d, logic neg);
        case (sh_rnd)
            fxa_pkg::RND_EVEN: return (r * 2 > d || (r * 2 == d && q[0])) ? q + 1 : q;
            fxa_pkg::RND_POS:  return (r != 0 && !neg) ? q + 1 : q;
            fxa_pkg::RND_NEG:  return (r != 0 && neg) ? q + 1 : q;
            default:           return q;
        endcase
    endfunction

    // Expected result word and divide-by-zero flag for one command.
    function automatic alu_out_t alu_predict(fxa_pkg::op_t op, logic [31:0] xi,
                                             logic [31:0] yi);
        int unsigned a, b, w;
        logic [63:0] mask, x, y, mx, my, q, p, d, r;
        logic nx, ny, neg;
        alu_out_t o;
        a = (sh_int < 1) ? 1 : ((sh_int > 32) ? 32 : sh_int);
        b = (sh_frac > 32 - a) ? 32 - a : sh_frac;
        w = a + b;
        mask = (64'd1 << w) - 1;
        x = {32'd0, xi} & mask;
        y = {32'd0, yi} & mask;
        o.dz = 1'b0;
        nx = x[w-1];
        ny = y[w-1];
        mx = nx ? (64'd1 << w) - x : x;
        my = ny ? (64'd1 << w) - y : y;
        neg = nx ^ ny;
        q = 0;
        case (op)
            fxa_pkg::OP_ADD: q = x + y;
            fxa_pkg::OP_SUB: q = x - y;
            fxa_pkg::OP_MUL:
            begin
                p = mx * my;
                d = 64'd1 << b;
                q = round_q(p >> b, p & (d - 1), d, neg);
                if (neg) q = -q;
            end
            default:
            begin
                if (my == 0)
                    o.dz = 1'b1;
                else
                begin
                    p = mx << b;
                    r = p % my;
                    q = round_q(p / my, r, my, neg);
                    if (neg) q = -q;
                end
            end
        endcase
        o.res = o.dz ? 32'd0 : 32'(q & mask);
        return o;
    endfunction

    // Result checker: sampled at the rising edge.
    always @(posedge clk)
    begin
        alu_out_t e;
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result word with nothing expected: %h", result_word);
                fails++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (result_word !== e.res)
                begin
                    $error("result_word expected %h actual %h", e.res, result_word);
                    fails++;
                end
                if (div_by_zero !== e.dz)
                begin
                    $error("div_by_zero expected %b actual %b", e.dz, div_by_zero);
                    fails++;
                end
            end
        end
    end

    // Watchdog on the total cycle count.
    always @(posedge clk)
    begin
        if (cycles > CYC_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [fxa_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= fxa_pkg::CFG_DATA_W'(val);
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            fxa_pkg::REG_INT_BITS:  sh_int = 6'(val);
            fxa_pkg::REG_FRAC_BITS: sh_frac = 5'(val);
            default:                sh_rnd = fxa_pkg::round_t'(val[1:0]);
        endcase
    endtask

    // Drive one command at the falling edge and hold until accepted.
    task automatic send_word(fxa_pkg::op_t op, logic [31:0] x, logic [31:0] y,
                             logic has_exp, alu_out_t forced);
        @(negedge clk);
        start <= 1'b1;
        operation <= op;
        operand_x <= x;
        operand_y <= y;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_q.push_back(has_exp ? forced : alu_predict(op, x, y));
    endtask

    task automatic go_idle();
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Wait until every expected word has arrived, then let the pipe drain.
    task automatic drain();
        go_idle();
        while (pending_q.size() != 0) @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
    endtask

    task automatic random_phase(int n, int unsigned w);
        int sent;
        int burst;
        logic [31:0] x, y;
        fxa_pkg::op_t op;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < n)
            begin
                op = fxa_pkg::op_t'($urandom_range(0, 3));
                x = $urandom();
                y = $urandom();
                case ($urandom_range(0, 9))
                    0: y = 32'd0;
                    1: x = 32'd1 << (w - 1);
                    2: y = $urandom_range(0, 7);
                    3: x = 32'hFFFF_FFFF;
                    default: ;
                endcase
                if ($urandom_range(0, 3) == 0) y = y >> $urandom_range(0, 31);
                send_word(op, x, y, 1'b0, '0);
                sent++;
                burst--;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                go_idle();
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    row_t dir_tab[$];

    initial
    begin
        int a_vals[6];
        int b_vals[6];
        alu_out_t f;
        int unsigned w;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table at reset widths Q16.16; expected given where obvious.
        dir_tab.push_back({1'b1, fxa_pkg::OP_ADD, 32'h0001_0000, 32'h0002_0000,
                           32'h0003_0000, 1'b0});
        dir_tab.push_back({1'b1, fxa_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001,
                           32'h8000_0000, 1'b0});
        dir_tab.push_back({1'b1, fxa_pkg::OP_SUB, 32'h0000_0000, 32'h0000_0001,
                           32'hFFFF_FFFF, 1'b0});
        dir_tab.push_back({1'b1, fxa_pkg::OP_MUL, 32'h0002_0000, 32'h0003_0000,
                           32'h0006_0000, 1'b0});
        dir_tab.push_back({1'b1, fxa_pkg::OP_DIV, 32'h1234_5678, 32'h0000_0000,
                           32'h0000_0000, 1'b1});
        dir_tab.push_back({1'b1, fxa_pkg::OP_DIV, 32'hFFFF_FFFF, 32'h0000_0000,
                           32'h0000_0000, 1'b1});
        dir_tab.push_back({1'b1, fxa_pkg::OP_MUL, 32'h0000_0000, 32'hFFFF_FFFF,
                           32'h0000_0000, 1'b0});
        dir_tab.push_back({1'b0, fxa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000,
                           32'd0, 1'b0});
        dir_tab.push_back({1'b0, fxa_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF,
                           32'd0, 1'b0});
        dir_tab.push_back({1'b0, fxa_pkg::OP_DIV, 32'h0001_0000, 32'h0003_0000,
                           32'd0, 1'b0});
        dir_tab.push_back({1'b0, fxa_pkg::OP_DIV, 32'hFFFF_0000, 32'h0003_0000,
                           32'd0, 1'b0});
        dir_tab.push_back({1'b0, fxa_pkg::OP_MUL, 32'h0000_8000, 32'h0000_0001,
                           32'd0, 1'b0});
        dir_tab.push_back({1'b0, fxa_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0000_8000,
                           32'd0, 1'b0});
        dir_tab.push_back({1'b0, fxa_pkg::OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF,
                           32'd0, 1'b0});

        // Walk the table under each rounding mode.
        for (int m = 0; m < 4; m++)
        begin
            write_reg(fxa_pkg::REG_ROUND_MODE, m);
            foreach (dir_tab[i])
            begin
                f.res = dir_tab[i].res;
                f.dz = dir_tab[i].dz;
                send_word(dir_tab[i].op, dir_tab[i].x, dir_tab[i].y, dir_tab[i].has_exp, f);
            end
            drain();
        end

        // Random phases across width settings, extremes and out-of-range values.
        a_vals = '{16, 1, 32, 0, 40, 8};
        b_vals = '{16, 0, 31, 31, 5, 3};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(fxa_pkg::REG_INT_BITS, a_vals[p]);
            write_reg(fxa_pkg::REG_FRAC_BITS, b_vals[p]);
            for (int m = 0; m < 4; m++)
            begin
                write_reg(fxa_pkg::REG_ROUND_MODE, (m + p) % 4);
                w = (sh_int < 1) ? 1 : ((sh_int > 32) ? 32 : sh_int);
                w = w + ((sh_frac > 32 - w) ? 32 - w : sh_frac);
                random_phase(N_RANDOM / 24, w);
                drain();
            end
        end

        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
